// ===== hw/rtl/mpsq_pkg.sv =====
// Shared types and constants of the melody playlist sequencer.
package mpsq_pkg;

  // Command codes carried in the input tuser field.
  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_PLAY       = 3'd1,
    CMD_APPEND     = 3'd2,
    CMD_REMOVE     = 3'd3,
    CMD_WRITE_NOTE = 3'd4
  } cmd_t;

  // Player modes.
  typedef enum logic [1:0] {
    MODE_PAUSE = 2'd0,
    MODE_START = 2'd1,
    MODE_PLAY  = 2'd2,
    MODE_GAP   = 2'd3
  } mode_t;

  localparam int CMD_W      = 3;
  localparam int ADDR_W     = 10;
  localparam int COUNT_W    = 11;
  localparam int FREQ_W     = 16;
  localparam int DUR_W      = 16;
  localparam int INDEX_W    = 4;
  localparam int QUEUED_W   = 5;
  localparam int GAP_W      = 16;
  localparam int ELAPSED_W  = 17;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 24;

  // Song base plus note position, before reduction to a note address.
  localparam int SUM_W = 12;

  localparam logic [GAP_W-1:0] GAP_MS_RESET = 16'd600;

endpackage

// ===== hw/rtl/melody_playlist_sequencer_unit.sv =====
// Top level of the melody playlist sequencer: command sequencer around note and playlist RAMs.
//
//   channel   direction  handshake                   contents
//   s_*       in         s_tvalid / s_tready         one command word
//   m_*       out        m_tvalid / m_tready         tone and status word after each command
//   cfg_*     in         cfg_valid / cfg_ready       gap_ms register
//
// Play, append, ignored removes and unknown commands go from decode straight to the result.
// A note write reduces the address modulo the memory depth by a reciprocal multiply and
// then a multiply-subtract. A remove shifts each entry above the removed one down by one.
// On a tick, each move on a note reads the playlist head, reduces the note address and
// reads the note RAM; a finished song adds the shift of the playlist entries.
// After reset the block accepts a command in the next cycle; RAM contents are not cleared.
// A result waiting on m_tready does not block the next command, only the one after it.
module melody_playlist_sequencer_unit #(
  parameter int PLAYLIST_DEPTH = 16,
  parameter int NOTE_MEM_DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // note_addr, note_count, note_freq, note_dur, song_index, zero fill
  input  logic [mpsq_pkg::IN_DATA_W-1:0]    s_tdata,
  // cmd
  input  logic [mpsq_pkg::CMD_W-1:0]        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // tone_on, tone_freq, launched, songs_queued, zero fill
  output logic [mpsq_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mpsq_pkg::GAP_W-1:0]        cfg_data
);

  localparam int QW        = $clog2(PLAYLIST_DEPTH + 1);
  localparam int LI_W      = $clog2(PLAYLIST_DEPTH);
  localparam int NA_W      = $clog2(NOTE_MEM_DEPTH);
  localparam int CMP_W     = QW + mpsq_pkg::INDEX_W;
  localparam int ENTRY_W   = mpsq_pkg::COUNT_W + mpsq_pkg::ADDR_W;
  localparam int NOTE_W    = mpsq_pkg::DUR_W + mpsq_pkg::FREQ_W;

  // The reciprocal is rounded up so that the quotient is exact for every SUM_W-bit sum.
  localparam int RCP_SH    = mpsq_pkg::SUM_W + NA_W;
  localparam int RCP_W     = mpsq_pkg::SUM_W + 2;
  localparam int PROD_W    = mpsq_pkg::SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP =
    RCP_W'((64'd1 << RCP_SH) / 64'(NOTE_MEM_DEPTH) + 64'd1);
  localparam logic [mpsq_pkg::SUM_W-1:0] DEPTH_LOW = mpsq_pkg::SUM_W'(NOTE_MEM_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_EVAL,
    S_LIST_RD,
    S_LIST_EVAL,
    S_MOD,
    S_MOD_SUB,
    S_NOTE_RD,
    S_NOTE_EVAL,
    S_NOTE_WR,
    S_SH_CHK,
    S_SH_RD,
    S_SH_WR,
    S_DONE
  } state_t;

  state_t state;

  // Latched command word.
  mpsq_pkg::cmd_t                  cmd_q;
  logic [mpsq_pkg::ADDR_W-1:0]     in_addr;
  logic [mpsq_pkg::COUNT_W-1:0]    in_count;
  logic [mpsq_pkg::FREQ_W-1:0]     in_freq;
  logic [mpsq_pkg::DUR_W-1:0]      in_dur;
  logic [mpsq_pkg::INDEX_W-1:0]    in_index;

  // Player state.
  logic [QW-1:0]                   queue_len;
  mpsq_pkg::mode_t                 player_mode;
  logic                            note_waiting;
  logic [mpsq_pkg::COUNT_W-1:0]    note_pos;
  logic [mpsq_pkg::ELAPSED_W-1:0]  wait_elapsed;
  logic                            launch_flag;
  logic                            tone_on;
  logic [mpsq_pkg::FREQ_W-1:0]     tone_freq;
  logic [mpsq_pkg::GAP_W-1:0]      gap_ms;

  // Address reduction and playlist shift.
  logic [mpsq_pkg::SUM_W-1:0]      mod_val;
  logic [PROD_W-1:0]               mod_prod;
  logic [LI_W-1:0]                 sh_i;

  // RAM ports.
  logic                            list_we;
  logic [LI_W-1:0]                 list_waddr;
  logic [ENTRY_W-1:0]              list_wdata;
  logic [LI_W-1:0]                 list_raddr;
  logic [ENTRY_W-1:0]              list_rdata;
  logic                            note_we;
  logic [NA_W-1:0]                 note_addr;
  logic [NOTE_W-1:0]               note_rdata;

  logic [mpsq_pkg::COUNT_W-1:0]    head_len;
  logic [mpsq_pkg::ADDR_W-1:0]     head_base;
  logic [mpsq_pkg::FREQ_W-1:0]     rd_freq;
  logic [mpsq_pkg::DUR_W-1:0]      rd_dur;
  logic [mpsq_pkg::SUM_W-1:0]      mod_quot;
  logic [mpsq_pkg::SUM_W-1:0]      mod_back;
  logic                            out_free;

  assign s_tready  = (state == S_IDLE) && !rst;
  assign cfg_ready = !rst;
  assign out_free  = !m_tvalid || m_tready;

  assign head_len  = (queue_len == '0) ? '0 : list_rdata[ENTRY_W-1:mpsq_pkg::ADDR_W];
  assign head_base = list_rdata[mpsq_pkg::ADDR_W-1:0];
  assign rd_freq   = note_rdata[mpsq_pkg::FREQ_W-1:0];
  assign rd_dur    = note_rdata[NOTE_W-1:mpsq_pkg::FREQ_W];

  // The remainder is below 2**SUM_W, so the product back is only needed modulo that.
  assign mod_quot = mpsq_pkg::SUM_W'(mod_prod >> RCP_SH);
  assign mod_back = mod_quot * DEPTH_LOW;

  // Playlist RAM: appends write at the tail, the shift copies entry i+1 down to i.
  always_comb begin
    list_we    = 1'b0;
    list_waddr = sh_i;
    list_wdata = list_rdata;
    list_raddr = '0;
    if (state == S_DECODE && cmd_q == mpsq_pkg::CMD_APPEND &&
        queue_len < QW'(PLAYLIST_DEPTH)) begin
      list_we    = 1'b1;
      list_waddr = LI_W'(queue_len);
      list_wdata = {in_count, in_addr};
    end else if (state == S_SH_WR) begin
      list_we = 1'b1;
    end
    if (state == S_SH_RD) begin
      list_raddr = sh_i + LI_W'(1);
    end
  end

  assign note_we   = (state == S_NOTE_WR);
  assign note_addr = NA_W'(mod_val);

  mpsq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PLAYLIST_DEPTH)
  ) u_list_ram (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (list_wdata),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

  mpsq_ram #(
    .WIDTH (NOTE_W),
    .DEPTH (NOTE_MEM_DEPTH)
  ) u_note_ram (
    .clk   (clk),
    .we    (note_we),
    .waddr (note_addr),
    .wdata ({in_dur, in_freq}),
    .raddr (note_addr),
    .rdata (note_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      queue_len    <= '0;
      player_mode  <= mpsq_pkg::MODE_PAUSE;
      note_waiting <= 1'b0;
      note_pos     <= '0;
      wait_elapsed <= '0;
      launch_flag  <= 1'b0;
      tone_on      <= 1'b0;
      tone_freq    <= '0;
      gap_ms       <= mpsq_pkg::GAP_MS_RESET;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        gap_ms <= cfg_data;
      end
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_q    <= mpsq_pkg::cmd_t'(s_tuser);
            in_addr  <= s_tdata[9:0];
            in_count <= s_tdata[20:10];
            in_freq  <= s_tdata[36:21];
            in_dur   <= s_tdata[52:37];
            in_index <= s_tdata[56:53];
            state    <= S_DECODE;
          end
        end

        S_DECODE: begin
          case (cmd_q)
            mpsq_pkg::CMD_TICK: begin
              if (wait_elapsed != '1) begin
                wait_elapsed <= wait_elapsed + 1'b1;
              end
              state <= S_EVAL;
            end
            mpsq_pkg::CMD_PLAY: begin
              launch_flag <= 1'b1;
              state       <= S_DONE;
            end
            mpsq_pkg::CMD_APPEND: begin
              if (queue_len < QW'(PLAYLIST_DEPTH)) begin
                queue_len <= queue_len + 1'b1;
              end
              state <= S_DONE;
            end
            mpsq_pkg::CMD_REMOVE: begin
              if (CMP_W'(in_index) < CMP_W'(queue_len)) begin
                sh_i  <= LI_W'(in_index);
                state <= S_SH_CHK;
              end else begin
                state <= S_DONE;
              end
            end
            mpsq_pkg::CMD_WRITE_NOTE: begin
              mod_val <= mpsq_pkg::SUM_W'(in_addr);
              state   <= S_MOD;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end

        // One player move; moves that advance loop back here.
        S_EVAL: begin
          case (player_mode)
            mpsq_pkg::MODE_PAUSE: begin
              if (launch_flag && queue_len != '0) begin
                player_mode <= mpsq_pkg::MODE_START;
              end else begin
                state <= S_DONE;
              end
            end
            mpsq_pkg::MODE_START: begin
              if (queue_len == '0) begin
                player_mode <= mpsq_pkg::MODE_PAUSE;
                launch_flag <= 1'b0;
              end else begin
                player_mode <= mpsq_pkg::MODE_PLAY;
              end
            end
            mpsq_pkg::MODE_PLAY: begin
              state <= S_LIST_RD;
            end
            default: begin
              if (wait_elapsed > mpsq_pkg::ELAPSED_W'(gap_ms)) begin
                player_mode <= mpsq_pkg::MODE_START;
              end else begin
                state <= S_DONE;
              end
            end
          endcase
        end

        S_LIST_RD: begin
          state <= S_LIST_EVAL;
        end

        S_LIST_EVAL: begin
          if (note_pos < head_len) begin
            mod_val <= mpsq_pkg::SUM_W'(head_base) + mpsq_pkg::SUM_W'(note_pos);
            state   <= S_MOD;
          end else begin
            // Song finished: silence, drop the head entry and start the gap.
            tone_on      <= 1'b0;
            tone_freq    <= '0;
            note_pos     <= '0;
            note_waiting <= 1'b0;
            player_mode  <= mpsq_pkg::MODE_GAP;
            wait_elapsed <= '0;
            sh_i         <= '0;
            state        <= (queue_len != '0) ? S_SH_CHK : S_DONE;
          end
        end

        // Note address reduction: quotient by reciprocal multiply, then the remainder.
        S_MOD: begin
          mod_prod <= PROD_W'(mod_val) * PROD_W'(RCP);
          state    <= S_MOD_SUB;
        end

        S_MOD_SUB: begin
          mod_val <= mod_val - mod_back;
          state   <= (cmd_q == mpsq_pkg::CMD_WRITE_NOTE) ? S_NOTE_WR : S_NOTE_RD;
        end

        S_NOTE_WR: begin
          state <= S_DONE;
        end

        S_NOTE_RD: begin
          state <= S_NOTE_EVAL;
        end

        S_NOTE_EVAL: begin
          if (!note_waiting) begin
            // A freshly started note cannot end in the same tick.
            tone_on      <= (rd_freq != '0);
            tone_freq    <= rd_freq;
            wait_elapsed <= '0;
            note_waiting <= 1'b1;
            state        <= S_DONE;
          end else if (wait_elapsed > mpsq_pkg::ELAPSED_W'(rd_dur)) begin
            note_waiting <= 1'b0;
            note_pos     <= note_pos + 1'b1;
            state        <= S_EVAL;
          end else begin
            state <= S_DONE;
          end
        end

        S_SH_CHK: begin
          if ((QW'(sh_i) + QW'(1)) < queue_len) begin
            state <= S_SH_RD;
          end else begin
            queue_len <= queue_len - 1'b1;
            state     <= S_DONE;
          end
        end

        S_SH_RD: begin
          state <= S_SH_WR;
        end

        S_SH_WR: begin
          sh_i  <= sh_i + 1'b1;
          state <= S_SH_CHK;
        end

        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, mpsq_pkg::QUEUED_W'(queue_len), launch_flag,
                         tone_on ? tone_freq : '0, tone_on};
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/mpsq_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
module mpsq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
